[src/point_in_polygon_test_assert.svh]
// Assertion macros used by the point-in-polygon test RTL.
`ifndef POINT_IN_POLYGON_TEST_ASSERT_SVH
`define POINT_IN_POLYGON_TEST_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PIP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PIP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/pip_pkg.sv]
// Shared types and constants of the point-in-polygon test.
package pip_pkg;

	localparam int MAX_VERTICES_DEF = 64;
	localparam int QUEUE_DEPTH      = 2;

	// One classified request as it waits in the queue.
	typedef struct packed {
		logic               is_query;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic               restart;
	} item_t;

	// Queue head presented to the back end.
	typedef struct packed {
		logic  valid;
		item_t item;
	} req_t;

	// Back end status toward the front end.
	typedef struct packed {
		logic ready;
		logic walking;
	} sts_t;

endpackage

[src/pip_front.sv]
// Front end: request acceptance, classification and a short queue.
module pip_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               kind,
	input  logic signed [15:0] coord_x,
	input  logic signed [15:0] coord_y,
	input  logic               restart,
	output pip_pkg::req_t      req,
	input  pip_pkg::sts_t      sts
);
	import pip_pkg::*;

	localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	item_t          slot_q [QUEUE_DEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] fill_q;
	logic           push;
	logic           pop;
	item_t          in_item;

	assign busy = (fill_q == QCW'(QUEUE_DEPTH));
	assign push = start && !busy;
	assign pop  = req.valid && sts.ready;

	// Classify the request: kind one is a query.
	always_comb begin
		in_item.is_query = kind;
		in_item.x        = coord_x;
		in_item.y        = coord_y;
		in_item.restart  = restart;
	end

	assign req.valid = (fill_q != '0);
	assign req.item  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

[src/pip_back.sv]
// Back end: vertex store and the edge walk of a query.
module pip_back #(
	parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  pip_pkg::req_t req,
	output pip_pkg::sts_t sts,
	output logic          done,
	output logic          inside_res,
	output logic [6:0]    vertex_total,
	output logic          dropped_vertices
);
	import pip_pkg::*;

	localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int CW = $clog2(MAX_VERTICES + 1);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_WALK  = 3'b010,
		ST_FLUSH = 3'b100
	} back_state_t;

	back_state_t        state_q;
	logic [31:0]        mem [MAX_VERTICES];
	logic [31:0]        rd_data_s1;
	logic [CW-1:0]      count_q;
	logic               ovf_q;
	logic [AW-1:0]      idx_q;
	logic signed [15:0] qx_q;
	logic signed [15:0] qy_q;
	logic               parity_q;
	logic               v_s1;
	logic               first_s1;
	logic               last_s1;
	logic signed [15:0] prev_x_q;
	logic signed [15:0] prev_y_q;
	logic               v_s2;
	logic               last_s2;
	logic               strad_s2;
	logic               dneg_s2;
	logic signed [33:0] lhs_s2;
	logic signed [33:0] rhs_s2;
	logic               done_q;
	logic               inside_q;
	logic [6:0]         total_q;
	logic               drop_q;

	logic               pop;
	logic               pop_vtx;
	logic               pop_qry;
	logic [CW-1:0]      base;
	logic               room;
	logic [CW-1:0]      count_m1;
	logic [AW-1:0]      last_addr;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic               last_rd;
	logic [CW+6:0]      count_ext;
	logic               empty;
	logic signed [15:0] xi;
	logic signed [15:0] yi;
	logic               straddle;
	logic signed [16:0] d;
	logic signed [16:0] dxq;
	logic signed [16:0] dxj;
	logic signed [16:0] dyq;
	logic signed [33:0] lhs;
	logic signed [33:0] rhs;
	logic               crossing;
	logic               finish;

	assign pop     = req.valid && (state_q == ST_IDLE);
	assign pop_vtx = pop && !req.item.is_query;
	assign pop_qry = pop && req.item.is_query;

	assign base      = req.item.restart ? '0 : count_q;
	assign room      = (base < CW'(MAX_VERTICES));
	assign count_m1  = count_q - 1'b1;
	assign last_addr = count_m1[AW-1:0];
	assign empty     = (count_q == '0);
	assign count_ext = {7'd0, count_q};

	// First read fetches the closing vertex, then vertices in order.
	assign rd_en   = (pop_qry && !empty) || (state_q == ST_WALK);
	assign rd_addr = (state_q == ST_WALK) ? idx_q : last_addr;
	assign last_rd = (state_q == ST_WALK) && (idx_q == last_addr);

	always_ff @(posedge clk) begin
		if (pop_vtx && room) begin
			mem[base[AW-1:0]] <= {req.item.x, req.item.y};
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	// Edge (i, j): i is the vertex just read, j the one before it.
	always_comb begin
		xi       = rd_data_s1[31:16];
		yi       = rd_data_s1[15:0];
		straddle = ((yi <= qy_q) && (qy_q < prev_y_q)) || ((prev_y_q <= qy_q) && (qy_q < yi));
		d        = 17'(prev_y_q) - 17'(yi);
		dxq      = 17'(qx_q) - 17'(xi);
		dxj      = 17'(prev_x_q) - 17'(xi);
		dyq      = 17'(qy_q) - 17'(yi);
		lhs      = dxq * d;
		rhs      = dxj * dyq;
	end

	assign crossing = v_s2 && strad_s2 && (dneg_s2 ? (lhs_s2 > rhs_s2) : (lhs_s2 < rhs_s2));
	assign finish   = (state_q == ST_FLUSH) && v_s2 && last_s2;

	always_ff @(posedge clk) begin
		if (pop_qry) begin
			qx_q <= req.item.x;
			qy_q <= req.item.y;
		end
		if (v_s1) begin
			prev_x_q <= xi;
			prev_y_q <= yi;
		end
		strad_s2 <= straddle;
		dneg_s2  <= d[16];
		lhs_s2   <= lhs;
		rhs_s2   <= rhs;
		if (pop_qry) begin
			total_q <= count_ext[6:0];
			drop_q  <= ovf_q;
		end
		if (pop_qry && empty) begin
			inside_q <= 1'b0;
		end else if (finish) begin
			inside_q <= parity_q ^ crossing;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			ovf_q    <= 1'b0;
			idx_q    <= '0;
			parity_q <= 1'b0;
			v_s1     <= 1'b0;
			first_s1 <= 1'b0;
			last_s1  <= 1'b0;
			v_s2     <= 1'b0;
			last_s2  <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			v_s1     <= rd_en;
			first_s1 <= (state_q == ST_IDLE);
			last_s1  <= last_rd;
			v_s2     <= v_s1 && !first_s1;
			last_s2  <= v_s1 && last_s1;
			done_q   <= 1'b0;
			if (crossing) begin
				parity_q <= ~parity_q;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop_vtx) begin
						if (req.item.restart) begin
							ovf_q <= 1'b0;
						end
						if (room) begin
							count_q <= base + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
					end else if (pop_qry) begin
						parity_q <= 1'b0;
						idx_q    <= '0;
						if (empty) begin
							done_q <= 1'b1;
						end else begin
							state_q <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					idx_q <= idx_q + 1'b1;
					if (last_rd) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (finish) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign sts.ready        = (state_q == ST_IDLE);
	assign sts.walking      = (state_q != ST_IDLE);
	assign done             = done_q;
	assign inside_res       = inside_q;
	assign vertex_total     = total_q;
	assign dropped_vertices = drop_q;

endmodule

[src/point_in_polygon_test.sv]
// Top level of the even-odd point-in-polygon test.
//
// Requests enter on start and are taken at a rising edge where start is high
// and busy is low. A request with kind 0 loads one vertex (restart empties the
// polygon and clears the drop flag first); a vertex beyond MAX_VERTICES is
// dropped and flagged. A request with kind 1 queries a point and produces one
// result, shown for exactly one cycle with done high; the receiver cannot
// stall, so capture inside_res, vertex_total and dropped_vertices on that
// cycle. A two-entry queue sits in front of the engine, so busy rises only
// when both entries wait. The engine stores a vertex load while idle; a query
// walks the polygon one edge per cycle from the single vertex memory read
// port, after the closing-vertex fetch, and each edge passes two pipeline
// stages of multiply and compare; an empty polygon skips the walk.
// The result appears on the cycle after the engine finishes. Vertex
// memory is not cleared at reset; a query only visits written entries.
`include "point_in_polygon_test_assert.svh"

module point_in_polygon_test #(
	parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               kind,
	input  logic signed [15:0] coord_x,
	input  logic signed [15:0] coord_y,
	input  logic               restart,
	output logic               done,
	output logic               inside_res,
	output logic [6:0]         vertex_total,
	output logic               dropped_vertices
);
	import pip_pkg::*;

	req_t req;
	sts_t sts;

	// Accept and classify requests; hold them until the engine is free.
	pip_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.kind    (kind),
		.coord_x (coord_x),
		.coord_y (coord_y),
		.restart (restart),
		.req     (req),
		.sts     (sts)
	);

	// Store vertices and walk the edges of each query.
	pip_back #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.req              (req),
		.sts              (sts),
		.done             (done),
		.inside_res       (inside_res),
		.vertex_total     (vertex_total),
		.dropped_vertices (dropped_vertices)
	);

	// A full queue always presents a request to the engine.
	`PIP_ASSERT_IMP(a_busy_has_req, busy, req.valid, "queue full but no request presented")
	// Busy only rises after a request was taken.
	`PIP_ASSERT_IMP(a_busy_rise, $rose(busy), $past(start), "busy rose without a request")
	// A result is never shown while the engine is mid-walk.
	`PIP_ASSERT_NXT(a_done_idle, sts.walking && !(req.valid && sts.ready), !done || !sts.walking,
		"result strobe overlaps an edge walk")

endmodule
